### rtl/ikht_pkg.sv
// Package: widths, status codes, operation codes and the key mix function.
`default_nettype none
package ikht_pkg;
	localparam int BUCKETS_DEF    = 256;
	localparam int ENTRIES_DEF    = 256;
	localparam int VALUE_BITS_DEF = 32;
	localparam int KEY_W   = 64;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 3;
	localparam int VOUT_W  = 32;
	localparam int COUNT_W = 9;

	typedef enum logic [OP_W-1:0] {
		OP_SET = 2'd0, OP_GET = 2'd1, OP_REMOVE = 2'd2, OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED = 3'd0, ST_UPDATED = 3'd1, ST_HIT = 3'd2, ST_MISS = 3'd3,
		ST_FULL = 3'd4, ST_ZERO = 3'd5, ST_CLEARED = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_WIPE, S_IDLE, S_HASH, S_HEAD, S_WALK, S_DECIDE, S_FREE, S_DONE
	} state_t;

	// First half of the shift-add-xor mix.
	function automatic logic [KEY_W-1:0] mix_a(input logic [KEY_W-1:0] k_in);
		logic [KEY_W-1:0] k;
		k = (~k_in) + (k_in << 21);
		k = k ^ (k >> 24);
		k = (k + (k << 3)) + (k << 8);
		k = k ^ (k >> 14);
		return k;
	endfunction

	// Second half; bucket selection takes the low $clog2(BUCKETS) bits.
	function automatic logic [KEY_W-1:0] mix_b(input logic [KEY_W-1:0] k_in);
		logic [KEY_W-1:0] k;
		k = (k_in + (k_in << 2)) + (k_in << 4);
		k = k ^ (k >> 28);
		k = k + (k << 31);
		return k;
	endfunction
endpackage
`default_nettype wire

### rtl/ikht_if.sv
// Valid/ready channel interface carrying one word of payload type T.
`default_nettype none
interface ikht_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/ikht_mem.sv
// Simple dual-port synchronous RAM, one write and one read port, registered read.
`default_nettype none
module ikht_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/integer_key_hash_table.sv
// Top level: chained hash table with sequencer, bucket/entry/free-stack memories.
`default_nettype none
// Key-value table with 64-bit keys in a pool of ENTRIES slots chained from
// BUCKETS bucket heads. One operation is handled at a time. For set, get and
// remove the sequence is: the accept cycle (first half of the mix); a hash
// cycle that finishes the mix and addresses the bucket head; a bucket-head
// read; then a chain walk with a read step and a compare step per visited
// entry (one entry memory read port). After that come a decide cycle, a pop
// of a free slot when a set must insert, and a result cycle. A clear goes
// straight from the accept cycle to the result cycle. Clear and reset both
// start a wiping pass that rewrites bucket heads and the free stack; the
// block accepts no word during it. The result sits in an output register. A
// new word is taken only once that register is empty or is being read in
// the same cycle.
module integer_key_hash_table
	import ikht_pkg::*;
#(
	parameter int BUCKETS    = BUCKETS_DEF,
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ikht_if.sink   req,
	ikht_if.source rsp
);
	localparam int BW   = $clog2(BUCKETS);
	localparam int EW   = $clog2(ENTRIES);
	localparam int PW   = EW + 1;            // slot index with null bit on top
	localparam int WIPE = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
	localparam int WW   = $clog2(WIPE) + 1;
	localparam logic [PW-1:0] NIL = PW'(ENTRIES);
	localparam int ROW = KEY_W + VALUE_BITS + PW;

	// req.data = {operation, lookup_key, new_value}; rsp.data = {status,value_out,entry_count}
	logic [OP_W-1:0]   in_op;
	logic [KEY_W-1:0]  in_key;
	logic [VOUT_W-1:0] in_val;
	assign {in_op, in_key, in_val} = req.data;

	state_t state_q, state_d;
	logic [WW-1:0] wipe_q;
	op_t op_q;
	logic [KEY_W-1:0] key_q, mix_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [BW-1:0] bkt_q;
	logic [PW-1:0] cur_q, prev_q, steps_q, top_q, cnt_q;
	logic walk_rd_q;      // entry read in flight for cur_q
	logic found_q;
	logic [PW-1:0] next_found_q;
	logic [VALUE_BITS-1:0] vfound_q;
	logic out_v_q;
	logic [STAT_W-1:0] out_st_q;
	logic [VOUT_W-1:0] out_val_q;
	logic [COUNT_W-1:0] out_cnt_q;

	// previous row copy, needed to relink on remove
	logic [ROW-1:0] prevrow_q;
	logic [PW-1:0] headv_q;
	// pool-full flag captured at decide time
	logic stfull_q;

	// bucket index, finished during the hash cycle so the head read can start then
	logic [BW-1:0] bkt_d;
	assign bkt_d = BW'(mix_b(mix_q));

	// memories
	logic hd_we; logic [BW-1:0] hd_wa, hd_ra; logic [PW-1:0] hd_wd, hd_rd;
	logic en_we; logic [EW-1:0] en_wa, en_ra; logic [ROW-1:0] en_wd, en_rd;
	logic fs_we; logic [EW-1:0] fs_wa, fs_ra, fs_wd, fs_rd;

	ikht_mem #(.DEPTH(BUCKETS), .WIDTH(PW)) u_head (
		.clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
	ikht_mem #(.DEPTH(ENTRIES), .WIDTH(ROW)) u_entry (
		.clk(clk), .we(en_we), .waddr(en_wa), .wdata(en_wd), .raddr(en_ra), .rdata(en_rd));
	ikht_mem #(.DEPTH(ENTRIES), .WIDTH(EW)) u_free (
		.clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));

	logic [KEY_W-1:0] row_key; logic [VALUE_BITS-1:0] row_val; logic [PW-1:0] row_next;
	assign {row_key, row_val, row_next} = en_rd;

	logic slot_ok, hit_now;
	assign slot_ok = !cur_q[EW] && (steps_q < PW'(ENTRIES));
	assign hit_now = walk_rd_q && slot_ok && (row_key == key_q);

	logic out_free;
	assign out_free = !out_v_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	logic take;
	assign take = req.valid && req.ready;

	// decision signals
	logic need_pop;
	assign need_pop = (op_q == OP_SET) && (val_q != '0) && !found_q && (top_q != '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_WIPE: if (wipe_q == WW'(WIPE - 1)) state_d = S_IDLE;
			S_IDLE: if (take) state_d = (op_t'(in_op) == OP_CLEAR) ? S_DONE : S_HASH;
			S_HASH: state_d = S_HEAD;
			S_HEAD: state_d = S_WALK;
			S_WALK: begin
				if (walk_rd_q && (!slot_ok || row_key == key_q)) state_d = S_DECIDE;
				else if (!walk_rd_q && !slot_ok) state_d = S_DECIDE;
			end
			S_DECIDE: state_d = need_pop ? S_FREE : S_DONE;
			S_FREE: state_d = S_DONE;
			S_DONE: if (out_free) state_d = (op_q == OP_CLEAR) ? S_WIPE : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		hd_we = 1'b0; hd_wa = bkt_q; hd_wd = NIL; hd_ra = bkt_q;
		en_we = 1'b0; en_wa = cur_q[EW-1:0]; en_wd = en_rd; en_ra = cur_q[EW-1:0];
		fs_we = 1'b0; fs_wa = wipe_q[EW-1:0]; fs_wd = wipe_q[EW-1:0];
		fs_ra = EW'(top_q - PW'(1));
		case (state_q)
			S_WIPE: begin
				hd_we = (wipe_q < WW'(BUCKETS)); hd_wa = wipe_q[BW-1:0];
				fs_we = (wipe_q < WW'(ENTRIES));
			end
			S_HASH: hd_ra = bkt_d;
			S_WALK: if (walk_rd_q && slot_ok && row_key != key_q)
				en_ra = row_next[EW-1:0];
			S_DECIDE: begin
				if (op_q == OP_SET && val_q != '0 && found_q) begin
					en_we = 1'b1; en_wa = cur_q[EW-1:0];
					en_wd = {key_q, val_q, next_found_q};
				end else if (op_q == OP_REMOVE && found_q) begin
					fs_we = (top_q < PW'(ENTRIES));
					fs_wa = top_q[EW-1:0]; fs_wd = cur_q[EW-1:0];
					if (prev_q == NIL) begin
						hd_we = 1'b1; hd_wd = next_found_q;
					end else begin
						en_we = 1'b1; en_wa = prev_q[EW-1:0];
						en_wd = {prevrow_q[ROW-1:PW], next_found_q};
					end
				end
			end
			S_FREE: begin
				en_we = 1'b1; en_wa = fs_rd; en_wd = {key_q, val_q, headv_q};
				hd_we = 1'b1; hd_wd = {1'b0, fs_rd};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE; wipe_q <= '0; top_q <= PW'(ENTRIES); cnt_q <= '0;
			out_v_q <= 1'b0; walk_rd_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// raise on a new result, drop once the current one is read
			if (state_q == S_DONE && out_free) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
			case (state_q)
				S_WIPE: begin
					wipe_q <= wipe_q + WW'(1);
					top_q <= PW'(ENTRIES); cnt_q <= '0;
				end
				S_IDLE: wipe_q <= '0;
				S_HEAD: walk_rd_q <= 1'b0;
				S_WALK: begin
					if (!walk_rd_q) walk_rd_q <= 1'b1;
					else if (slot_ok && row_key != key_q) walk_rd_q <= 1'b0;
				end
				S_DECIDE: begin
					walk_rd_q <= 1'b0;
					if (op_q == OP_REMOVE && found_q) begin
						if (top_q < PW'(ENTRIES)) top_q <= top_q + PW'(1);
						if (cnt_q != '0) cnt_q <= cnt_q - PW'(1);
					end
				end
				S_FREE: begin
					top_q <= top_q - PW'(1); cnt_q <= cnt_q + PW'(1);
				end
				S_DONE: if (out_free && op_q == OP_CLEAR) begin
					top_q <= PW'(ENTRIES); cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (take) begin
				op_q <= op_t'(in_op); key_q <= in_key;
				val_q <= VALUE_BITS'(in_val);
				mix_q <= mix_a(in_key);
				found_q <= 1'b0; prev_q <= NIL;
			end
			S_HASH: bkt_q <= bkt_d;
			S_HEAD: begin
				cur_q <= hd_rd[EW] ? NIL : hd_rd;
				headv_q <= hd_rd; steps_q <= '0;
			end
			S_WALK: if (walk_rd_q) begin
				if (hit_now) begin
					found_q <= 1'b1; next_found_q <= row_next; vfound_q <= row_val;
				end else if (slot_ok) begin
					prev_q <= cur_q; prevrow_q <= en_rd;
					cur_q <= row_next; steps_q <= steps_q + PW'(1);
				end
			end
			default: ;
		endcase
		if (state_q == S_DONE && out_free) begin
			case (op_q)
				OP_CLEAR: begin
					out_st_q <= ST_CLEARED; out_val_q <= '0; out_cnt_q <= '0;
				end
				OP_SET: begin
					out_val_q <= '0;
					out_cnt_q <= COUNT_W'(cnt_q);
					if (val_q == '0) out_st_q <= ST_ZERO;
					else if (found_q) out_st_q <= ST_UPDATED;
					else if (stfull_q) out_st_q <= ST_FULL;
					else out_st_q <= ST_INSERTED;
				end
				default: begin
					out_st_q <= found_q ? ST_HIT : ST_MISS;
					out_val_q <= found_q ? VOUT_W'(vfound_q) : '0;
					out_cnt_q <= COUNT_W'(cnt_q);
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE) stfull_q <= (top_q == '0);
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = {out_st_q, out_val_q, out_cnt_q};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= PW'(ENTRIES)) else $error("pair count over pool size");
	a_pool_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (top_q + cnt_q == PW'(ENTRIES)))
		else $error("free stack and pair count disagree");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req.ready) else $error("word taken while busy");
`endif
endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the integer-key hash table: queued stimulus, predictor, word checker.
module testbench;
	import ikht_pkg::*;

	typedef struct packed {
		op_t         operation;
		logic [63:0] lookup_key;
		logic [31:0] new_value;
	} req_word_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] value_out;
		logic [8:0]  entry_count;
	} rsp_word_t;

	localparam int NPOOL = 256;
	localparam int NIL = NPOOL;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	int   cycle;
	int   errors;
	int   sink_hold;

	req_word_t pending_words[$];
	rsp_word_t expected_rsp[$];
	logic [63:0] key_pool[48];

	// Shadow copy of the table.
	int          head_of[NPOOL];
	logic [63:0] slot_key[NPOOL];
	logic [31:0] slot_val[NPOOL];
	int          slot_link[NPOOL];
	int          free_slots[NPOOL];
	int          free_cnt;
	int          pairs;

	ikht_if #(.T(req_word_t)) req_ch ();
	ikht_if #(.T(rsp_word_t)) rsp_ch ();

	integer_key_hash_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] bucket_pick(input logic [63:0] key);
		logic [63:0] h;
		h = (~key) + (key << 21);
		h = h ^ (h >> 24);
		h = (h + (h << 3)) + (h << 8);
		h = h ^ (h >> 14);
		h = (h + (h << 2)) + (h << 4);
		h = h ^ (h >> 28);
		h = h + (h << 31);
		return h[7:0];
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < NPOOL; i++) begin
			head_of[i] = NIL;
			free_slots[i] = i;
		end
		free_cnt = NPOOL;
		pairs = 0;
	endfunction

	// Apply one accepted word to the shadow table and queue the expected result.
	function automatic void predict_table_op(input req_word_t w);
		rsp_word_t r;
		int b, cur, prev, hit, steps, s;
		r.status = ST_CLEARED;
		r.value_out = '0;
		if (w.operation == OP_CLEAR) begin
			wipe_table();
		end else begin
			b = bucket_pick(w.lookup_key);
			cur = head_of[b];
			prev = NIL;
			hit = NIL;
			steps = 0;
			while (cur < NPOOL && steps < NPOOL && hit == NIL) begin
				if (slot_key[cur] == w.lookup_key) begin
					hit = cur;
				end else begin
					prev = cur;
					cur = slot_link[cur];
					steps++;
				end
			end
			if (w.operation == OP_SET) begin
				if (w.new_value == 0) begin
					r.status = ST_ZERO;
				end else if (hit != NIL) begin
					slot_val[hit] = w.new_value;
					r.status = ST_UPDATED;
				end else if (free_cnt == 0) begin
					r.status = ST_FULL;
				end else begin
					free_cnt--;
					s = free_slots[free_cnt];
					slot_key[s] = w.lookup_key;
					slot_val[s] = w.new_value;
					slot_link[s] = head_of[b];
					head_of[b] = s;
					pairs++;
					r.status = ST_INSERTED;
				end
			end else if (hit == NIL) begin
				r.status = ST_MISS;
			end else begin
				r.value_out = slot_val[hit];
				r.status = ST_HIT;
				if (w.operation == OP_REMOVE) begin
					if (prev == NIL)
						head_of[b] = slot_link[hit];
					else
						slot_link[prev] = slot_link[hit];
					if (free_cnt < NPOOL) begin
						free_slots[free_cnt] = hit;
						free_cnt++;
					end
					if (pairs > 0)
						pairs--;
				end
			end
		end
		r.entry_count = pairs[8:0];
		expected_rsp.push_back(r);
	endfunction

	task automatic queue_word(input op_t op, input logic [63:0] key, input logic [31:0] val);
		req_word_t w;
		w.operation = op;
		w.lookup_key = key;
		w.new_value = val;
		pending_words.push_back(w);
	endtask

	// Mostly keys from a small pool so chains, hits and updates occur; some wide random keys.
	task automatic queue_random(input int n);
		int pick;
		logic [63:0] key;
		logic [31:0] val;
		op_t op;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 40) op = OP_SET;
			else if (pick < 70) op = OP_GET;
			else if (pick < 98) op = OP_REMOVE;
			else op = OP_CLEAR;
			key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(47)]
				: {$urandom, $urandom};
			val = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
			queue_word(op, key, val);
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || req_ch.valid || expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Driver: predict on acceptance, then load the next word unless idling.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_table_op(req_ch.data);
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_words.size() != 0 &&
				    ((cycle >= 8000 && cycle < 12000) || $urandom_range(99) >= 31)) begin
					req_ch.valid <= 1'b1;
					req_ch.data <= pending_words.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random backpressure plus one long hold-off; check each word.
	always @(posedge clk or negedge arst_n) begin
		rsp_word_t exp_w;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			sink_hold <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsp.size() == 0) begin
					errors = errors + 1;
					$display("%0t unexpected word: actual %p", $time, rsp_ch.data);
				end else begin
					exp_w = expected_rsp.pop_front();
					if (rsp_ch.data.status !== exp_w.status) begin
						errors = errors + 1;
						$display("%0t status: expected %0d actual %0d", $time,
							exp_w.status, rsp_ch.data.status);
					end
					if (rsp_ch.data.value_out !== exp_w.value_out) begin
						errors = errors + 1;
						$display("%0t value_out: expected %h actual %h", $time,
							exp_w.value_out, rsp_ch.data.value_out);
					end
					if (rsp_ch.data.entry_count !== exp_w.entry_count) begin
						errors = errors + 1;
						$display("%0t entry_count: expected %0d actual %0d", $time,
							exp_w.entry_count, rsp_ch.data.entry_count);
					end
				end
			end
			if (cycle == 3000)
				sink_hold <= 500;
			else if (sink_hold > 0)
				sink_hold <= sink_hold - 1;
			rsp_ch.ready <= (cycle != 3000) && (sink_hold <= 1) &&
				((cycle >= 8000 && cycle < 12000) || $urandom_range(99) >= 31);
		end
	end

	initial begin
		cycle = 0;
		errors = 0;
		arst_n = 1'b0;
		wipe_table();
		for (int i = 0; i < 48; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every operation, each special case but a full pool.
		queue_word(OP_GET, 64'd0, 32'd0);
		queue_word(OP_SET, 64'd0, 32'd1);
		queue_word(OP_SET, '1, '1);
		queue_word(OP_GET, 64'd0, 32'd0);
		queue_word(OP_GET, '1, 32'd0);
		queue_word(OP_SET, 64'd0, 32'h8000_0000);
		queue_word(OP_SET, 64'h5555_5555_5555_5555, 32'd0);
		queue_word(OP_GET, 64'h5555_5555_5555_5555, 32'd0);
		queue_word(OP_REMOVE, 64'd0, 32'd0);
		queue_word(OP_REMOVE, 64'd0, 32'd0);
		queue_word(OP_GET, 64'd0, 32'd0);
		queue_word(OP_SET, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
		queue_word(OP_SET, 64'h8000_0000_0000_0000, 32'hAAAA_AAAA);
		queue_word(OP_REMOVE, '1, '1);
		queue_word(OP_CLEAR, '1, '1);
		queue_word(OP_GET, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
		queue_word(OP_CLEAR, 64'd0, 32'd0);
		queue_word(OP_SET, 64'h8000_0000_0000_0000, 32'd7);
		queue_word(OP_GET, 64'h8000_0000_0000_0000, 32'd0);
		queue_random(500);
		// Pause the sender until every result is back.
		wait_drained();

		// Fill the pool past capacity, then probe and drain part of it.
		queue_word(OP_CLEAR, 64'd0, 32'd0);
		for (int i = 0; i < 262; i++)
			queue_word(OP_SET, {$urandom, $urandom}, $urandom | 32'd1);
		queue_word(OP_SET, key_pool[0], 32'd9);
		queue_random(100);
		queue_word(OP_CLEAR, 64'd0, 32'd0);
		queue_random(800);

		wait_drained();
		repeat (600) @(posedge clk);
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("end of test: clean");
		end else begin
			if (expected_rsp.size() != 0)
				$display("%0t leftover words: expected %0d actual 0", $time,
					expected_rsp.size());
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
